[hw/rtl/altp_pkg.sv]
// ----------------------------------------------------------------------------
// altp_pkg : shared types and constants of the absolute loader tape parser
// Item kinds passed from the front end to the parser, parser phases, status
// codes and the packed result that leaves the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package altp_pkg;

  // Kind of one queued tape transaction, decided by the front end
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EOT     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // Parser phases within one tape block
  typedef enum logic [3:0] {
    PH_LEADER = 4'd0,
    PH_SIG_HI = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_LEN_HI = 4'd3,
    PH_ADR_LO = 4'd4,
    PH_ADR_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CHECK  = 4'd7,
    PH_HALT   = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    ST_RUN    = 4'd0,
    ST_DONE   = 4'd1,
    ST_NOSIG  = 4'd2,
    ST_NOHDR  = 4'd3,
    ST_BADLEN = 4'd4,
    ST_ADDR   = 4'd5,
    ST_EARLY  = 4'd6,
    ST_NOCHK  = 4'd7,
    ST_BADCHK = 4'd8
  } status_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    status_t     status;
    logic [23:0] bytes_loaded;
  } result_t;

  localparam logic [15:0] SIG_WORD   = 16'd1;
  localparam logic [15:0] HEADER_LEN = 16'd6;
  localparam logic [15:0] LEN_LIMIT  = 16'd32768;
  localparam logic [16:0] MEM_MAX    = 17'h10000;
  localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;

endpackage

`default_nettype wire

[hw/rtl/altp_front.sv]
// ----------------------------------------------------------------------------
// altp_front : input side of the tape parser
// Accepts tape transactions while the queue has room and classifies each one
// as restart, end of tape or plain byte before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module altp_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     tape_byte,
  input  wire logic           end_of_tape,
  input  wire logic           restart,
  input  wire logic           queue_full,
  output logic                push,
  output altp_pkg::item_t     push_item
);

  // Accept whenever the queue can take the transaction
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Classify: restart wins over end of tape, end of tape over the byte
  always_comb begin
    push_item.data = tape_byte;
    priority if (restart) begin
      push_item.kind = altp_pkg::KIND_RESTART;
    end else if (end_of_tape) begin
      push_item.kind = altp_pkg::KIND_EOT;
    end else begin
      push_item.kind = altp_pkg::KIND_BYTE;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/altp_queue.sv]
// ----------------------------------------------------------------------------
// altp_queue : short queue between front end and parser
// Register-based FIFO of classified tape transactions; lets either side stall
// without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module altp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire altp_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output altp_pkg::item_t      head_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  altp_pkg::item_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/altp_back.sv]
// ----------------------------------------------------------------------------
// altp_back : block parser and output register
// Runs the absolute loader block state machine on each queued transaction,
// keeps the memory size register and holds one result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module altp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [16:0]     cfg_wdata,
  input  wire logic            head_valid,
  input  wire altp_pkg::item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output altp_pkg::result_t    result
);

  logic [16:0]       memory_bytes;
  altp_pkg::phase_t  phase, phase_next;
  logic [7:0]        checksum, checksum_next;
  logic [7:0]        low_hold, low_hold_next;
  logic [15:0]       block_length, block_length_next;
  logic [16:0]       load_address, load_address_next;
  logic [14:0]       remaining, remaining_next;
  logic [23:0]       loaded_count, loaded_count_next;
  altp_pkg::status_t final_status, final_status_next;
  altp_pkg::result_t result_next;
  logic [16:0]       limit;
  logic [7:0]        sum;
  logic              eot;
  logic              wv;

  // Take a transaction when the output register is free or being emptied
  assign pop = head_valid && (!out_valid || out_ready);

  // Memory size register
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_bytes <= altp_pkg::MEM_MAX;
    end else if (cfg_we) begin
      memory_bytes <= cfg_wdata;
    end
  end

  assign limit = (memory_bytes > altp_pkg::MEM_MAX) ? altp_pkg::MEM_MAX : memory_bytes;
  assign sum   = checksum + head_item.data;
  assign eot   = (head_item.kind == altp_pkg::KIND_EOT);

  // Next parser state and result for the transaction at the queue head
  always_comb begin
    phase_next        = phase;
    checksum_next     = checksum;
    low_hold_next     = low_hold;
    block_length_next = block_length;
    load_address_next = load_address;
    remaining_next    = remaining;
    loaded_count_next = loaded_count;
    final_status_next = final_status;
    wv                = 1'b0;

    if (head_item.kind == altp_pkg::KIND_RESTART) begin
      phase_next        = altp_pkg::PH_LEADER;
      checksum_next     = '0;
      low_hold_next     = '0;
      block_length_next = '0;
      load_address_next = '0;
      remaining_next    = '0;
      loaded_count_next = '0;
      final_status_next = altp_pkg::ST_RUN;
    end else begin
      unique case (phase)
        altp_pkg::PH_LEADER: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_DONE;
            phase_next        = altp_pkg::PH_HALT;
          end else if (head_item.data != 8'd0) begin
            checksum_next = head_item.data;
            low_hold_next = head_item.data;
            phase_next    = altp_pkg::PH_SIG_HI;
          end
        end
        altp_pkg::PH_SIG_HI: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_DONE;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            checksum_next = sum;
            if ({head_item.data, low_hold} != altp_pkg::SIG_WORD) begin
              final_status_next = (loaded_count == '0) ? altp_pkg::ST_NOSIG
                                                       : altp_pkg::ST_DONE;
              phase_next        = altp_pkg::PH_HALT;
            end else begin
              phase_next = altp_pkg::PH_LEN_LO;
            end
          end
        end
        altp_pkg::PH_LEN_LO, altp_pkg::PH_ADR_LO: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_NOHDR;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            checksum_next = sum;
            low_hold_next = head_item.data;
            phase_next    = (phase == altp_pkg::PH_LEN_LO) ? altp_pkg::PH_LEN_HI
                                                           : altp_pkg::PH_ADR_HI;
          end
        end
        altp_pkg::PH_LEN_HI: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_NOHDR;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            checksum_next     = sum;
            block_length_next = {head_item.data, low_hold};
            phase_next        = altp_pkg::PH_ADR_LO;
          end
        end
        altp_pkg::PH_ADR_HI: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_NOHDR;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            checksum_next     = sum;
            load_address_next = {1'b0, head_item.data, low_hold};
            if (block_length < altp_pkg::HEADER_LEN ||
                block_length >= altp_pkg::LEN_LIMIT) begin
              final_status_next = altp_pkg::ST_BADLEN;
              phase_next        = altp_pkg::PH_HALT;
            end else if (block_length == altp_pkg::HEADER_LEN) begin
              final_status_next = altp_pkg::ST_DONE;
              phase_next        = altp_pkg::PH_HALT;
            end else begin
              remaining_next = 15'(block_length - altp_pkg::HEADER_LEN);
              phase_next     = altp_pkg::PH_DATA;
            end
          end
        end
        altp_pkg::PH_DATA: begin
          // Address check goes first, ahead of end of tape
          if (load_address >= limit) begin
            final_status_next = altp_pkg::ST_ADDR;
            phase_next        = altp_pkg::PH_HALT;
          end else if (eot) begin
            final_status_next = altp_pkg::ST_EARLY;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            wv                = 1'b1;
            checksum_next     = sum;
            load_address_next = load_address + 1'b1;
            if (loaded_count != altp_pkg::COUNT_MAX) begin
              loaded_count_next = loaded_count + 1'b1;
            end
            remaining_next = remaining - 1'b1;
            if (remaining == 15'd1) begin
              phase_next = altp_pkg::PH_CHECK;
            end
          end
        end
        altp_pkg::PH_CHECK: begin
          if (eot) begin
            final_status_next = altp_pkg::ST_NOCHK;
            phase_next        = altp_pkg::PH_HALT;
          end else begin
            checksum_next = sum;
            if (sum != 8'd0) begin
              final_status_next = altp_pkg::ST_BADCHK;
              phase_next        = altp_pkg::PH_HALT;
            end else begin
              phase_next = altp_pkg::PH_LEADER;
            end
          end
        end
        altp_pkg::PH_HALT: begin
          phase_next = altp_pkg::PH_HALT;
        end
        default: begin
          phase_next = altp_pkg::PH_HALT;
        end
      endcase
    end

    result_next.write_valid   = wv;
    result_next.write_address = wv ? load_address[15:0] : 16'd0;
    result_next.write_data    = wv ? head_item.data : 8'd0;
    result_next.status        = final_status_next;
    result_next.bytes_loaded  = loaded_count_next;
  end

  // Parser state register, advanced once per taken transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= altp_pkg::PH_LEADER;
      checksum     <= '0;
      low_hold     <= '0;
      block_length <= '0;
      load_address <= '0;
      remaining    <= '0;
      loaded_count <= '0;
      final_status <= altp_pkg::ST_RUN;
    end else if (pop) begin
      phase        <= phase_next;
      checksum     <= checksum_next;
      low_hold     <= low_hold_next;
      block_length <= block_length_next;
      load_address <= load_address_next;
      remaining    <= remaining_next;
      loaded_count <= loaded_count_next;
      final_status <= final_status_next;
    end
  end

  // Output register: load on a take, drop once the receiver has it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/absolute_loader_tape_parser_core.sv]
// ----------------------------------------------------------------------------
// absolute_loader_tape_parser_core : absolute loader paper tape parser
// Parses tape bytes into memory writes, with status and a loaded byte count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tape transaction: a byte,
//   an end-of-tape flag and a restart flag. Every accepted transaction gives
//   exactly one result on the output channel (out_valid/out_ready): a
//   possible memory write, the current status and the bytes-loaded count.
//   An accepted transaction waits in the queue until the parser takes it
//   from the head; its result is registered and offered from then on. The
//   parser takes one transaction per cycle, an 8-bit checksum add per step,
//   while its output register is free or being emptied by the receiver.
//   A queue of QUEUE_DEPTH entries sits between the input stage and the
//   parser. When the receiver stalls the parser holds its result and the
//   queue fills; in_ready falls only once the queue is full.
//   cfg_we/cfg_wdata write the memory size; write it only while idle.
//   Reset empties the queue and the output register, puts the parser at the
//   start of the leader with a zero count and sets the memory size to 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module absolute_loader_tape_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  tape_byte,
  input  wire logic        end_of_tape,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             write_valid,
  output logic [15:0]      write_address,
  output logic [7:0]       write_data,
  output logic [3:0]       status,
  output logic [23:0]      bytes_loaded
);

  logic              queue_full;
  logic              push;
  altp_pkg::item_t   push_item;
  logic              pop;
  logic              head_valid;
  altp_pkg::item_t   head_item;
  altp_pkg::result_t result;

  altp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tape_byte   (tape_byte),
    .end_of_tape (end_of_tape),
    .restart     (restart),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  altp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  altp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign write_valid   = result.write_valid;
  assign write_address = result.write_address;
  assign write_data    = result.write_data;
  assign status        = result.status;
  assign bytes_loaded  = result.bytes_loaded;

  // A store only happens while the parser is still running
  a_write_running : assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> status == altp_pkg::ST_RUN)
    else $error("memory write offered with a final status");

  // Address and data are zero when there is no store
  a_idle_payload : assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> write_address == 16'd0 && write_data == 8'd0)
    else $error("write payload not cleared without a store");

  // The parser never takes a transaction from an empty queue
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("parser took from an empty queue");

  // Nothing is offered in the cycle after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

`default_nettype wire
